>>> src/tgc_pkg.sv
// Shared types, codes and constants of the touch gesture classifier.
// Used by tgc_datapath, tgc_ctrl and touch_gesture_classifier.
`timescale 1ns / 1ps
package tgc_pkg;

  localparam int DEF_FRACTION_BITS = 16;
  localparam int DVD_W  = 56;   // divider dividend and quotient width
  localparam int DVS_W  = 18;   // divider divisor width
  localparam int SQ_W   = 50;   // square root radicand width
  localparam int ROOT_W = 25;
  localparam int DIV_CNT_W  = 6;
  localparam int SQRT_CNT_W = 5;

  localparam logic [35:0] FOUR_PI_Q32 = 36'd53972150818;
  localparam logic [38:0] TWO_PI_Q32  = 39'd26986075409;
  localparam logic [DVS_W-1:0] ROT_DIVISOR = DVS_W'(65535);

  localparam logic [2:0] K_BEGIN  = 3'd0;
  localparam logic [2:0] K_END    = 3'd1;
  localparam logic [2:0] K_ZOOM   = 3'd2;
  localparam logic [2:0] K_PAN    = 3'd3;
  localparam logic [2:0] K_ROTATE = 3'd4;
  localparam logic [2:0] K_TWO    = 3'd5;
  localparam logic [2:0] K_PRESS  = 3'd6;

  localparam logic [3:0] G_PRESS_TAP = 4'd0;
  localparam logic [3:0] G_TWO_TAP   = 4'd1;
  localparam logic [3:0] G_ROTATE    = 4'd2;
  localparam logic [3:0] G_PINCH     = 4'd3;
  localparam logic [3:0] G_SPREAD    = 4'd4;
  localparam logic [3:0] G_UP        = 4'd5;
  localparam logic [3:0] G_DOWN      = 4'd6;
  localparam logic [3:0] G_LEFT      = 4'd7;
  localparam logic [3:0] G_RIGHT     = 4'd8;

  localparam logic [1:0] REG_DPI    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STARTED = 2'd1,
    PH_WAITING = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EM_TAP     = 2'd0,
    EM_TWO     = 2'd1,
    EM_COMPARE = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               flag_begin;
    logic               flag_end;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [31:0]        argument;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         gesture;
    logic signed [15:0] event_x;
    logic signed [15:0] event_y;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      clr_ignore;
    logic      set_ignore;
    logic      phase_wr;
    phase_t    phase_val;
    logic      origin_wr;
    logic      ref_zero;
    logic      ref_cur;
    logic      cur_wr;
    logic      mul_en;
    logic      sqrt_start;
    logic      div_start;
    logic      emit;
    emit_sel_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       fb;
    logic       fe;
    logic       ignore;
    phase_t     phase;
    logic       pzero;
    logic       sqrt_busy;
    logic       div_busy;
    logic       over_th;
    logic       out_free;
  } stat_t;

endpackage

>>> src/tgc_datapath.sv
// Datapath: item and gesture state registers, square root and divider units,
// threshold compare and output register. Depends on tgc_pkg.
`timescale 1ns / 1ps
module tgc_datapath
  import tgc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  input  cmd_t      cmd,
  output stat_t     stat
);

  localparam int VW = 8 + FRACTION_BITS;
  localparam int RS = 32 - FRACTION_BITS;
  localparam logic [DVD_W-1:0] VAL_MAX = (DVD_W'(1) << (7 + FRACTION_BITS)) - DVD_W'(1);
  localparam logic [VW:0] TH_ROTATE = (VW+1)'(1) << (FRACTION_BITS - 2);
  localparam logic [VW:0] TH_PAN    = (VW+1)'(((1 << FRACTION_BITS) + 5) / 10);
  localparam logic [VW:0] TH_ZOOM   = (VW+1)'(((3 << FRACTION_BITS) + 20) / 40);

  in_item_t item;
  logic [9:0]  dpi;
  logic [15:0] scr_w, scr_h;
  phase_t phase;
  logic ignore_rest;
  logic signed [15:0] origin_x, origin_y, last_x, last_y;
  logic signed [VW-1:0] ref_value, cur;
  logic signed [16:0] dx, dy;

  logic [SQ_W-1:0] sq_src;
  logic [ROOT_W+1:0] sq_rem;
  logic [ROOT_W-1:0] root;
  logic [SQRT_CNT_W-1:0] sq_cnt;
  logic sqrt_busy;

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs, dv_rem;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic div_busy;

  // configuration and item
  always_ff @(posedge clk) begin
    if (rst) begin
      dpi <= 10'd96;
      scr_w <= 16'd1920;
      scr_h <= 16'd1080;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DPI:    dpi <= cfg_data[9:0];
        REG_WIDTH:  scr_w <= cfg_data;
        REG_HEIGHT: scr_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
  end

  // pan differences and squares
  logic signed [16:0] dx_c, dy_c;
  logic signed [33:0] dxsq, dysq;
  logic [33:0] sq_sum;
  logic [51:0] rot_prod;
  assign dx_c = {item.point_x[15], item.point_x} - {origin_x[15], origin_x};
  assign dy_c = {item.point_y[15], item.point_y} - {origin_y[15], origin_y};
  assign dxsq = dx_c * dx_c;
  assign dysq = dy_c * dy_c;
  assign sq_sum = $unsigned(dxsq) + $unsigned(dysq);
  assign rot_prod = item.argument[15:0] * FOUR_PI_Q32;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      dx <= dx_c;
      dy <= dy_c;
    end
  end

  // square root, two radicand bits a step
  logic [ROOT_W+3:0] sq_rem2;
  logic [ROOT_W+1:0] sq_trial;
  assign sq_rem2 = {sq_rem, sq_src[SQ_W-1 -: 2]};
  assign sq_trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy <= 1'b1;
    end else if (sqrt_busy && sq_cnt == SQRT_CNT_W'(ROOT_W - 1)) begin
      sqrt_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_src <= {sq_sum, 16'b0};
      sq_rem <= '0;
      root <= '0;
      sq_cnt <= '0;
    end else if (sqrt_busy) begin
      sq_src <= {sq_src[SQ_W-3:0], 2'b00};
      sq_cnt <= sq_cnt + 1'b1;
      if (sq_rem2 >= (ROOT_W+4)'(sq_trial)) begin
        sq_rem <= (ROOT_W+2)'(sq_rem2 - (ROOT_W+4)'(sq_trial));
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_rem2[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // restoring divider, one quotient bit a step
  logic [DVS_W-1:0] dpi_eff;
  logic [DVD_W-1:0] dvd_in;
  logic [DVS_W-1:0] dvs_in;
  logic [DVS_W:0] dv_sh;
  assign dpi_eff = (dpi == 10'd0) ? DVS_W'(1) : DVS_W'(dpi);

  always_comb begin
    case (item.kind)
      K_ROTATE: begin
        dvd_in = DVD_W'(rot_prod);
        dvs_in = ROT_DIVISOR;
      end
      K_ZOOM: begin
        dvd_in = DVD_W'(item.argument) << FRACTION_BITS;
        dvs_in = dpi_eff;
      end
      default: begin
        dvd_in = DVD_W'(root) << FRACTION_BITS;
        dvs_in = dpi_eff << 8;
      end
    endcase
  end

  assign dv_sh = {dv_rem, dvd[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && dv_cnt == DIV_CNT_W'(DVD_W - 1)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= dvd_in;
      dvs <= dvs_in;
      dv_rem <= '0;
      dv_cnt <= '0;
    end else if (div_busy) begin
      dv_cnt <= dv_cnt + 1'b1;
      if (dv_sh >= {1'b0, dvs}) begin
        dv_rem <= DVS_W'(dv_sh - {1'b0, dvs});
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  // value from the quotient
  logic signed [38:0] rot_t;
  logic [37:0] rot_mag, rot_rnd;
  logic signed [VW-1:0] cur_calc;
  assign rot_t = $signed({1'b0, dvd[37:0]}) - $signed(TWO_PI_Q32);
  assign rot_mag = rot_t[38] ? 38'(-rot_t) : rot_t[37:0];
  assign rot_rnd = (rot_mag + (38'(1) << (RS - 1))) >> RS;

  always_comb begin
    if (item.kind == K_ROTATE) begin
      cur_calc = rot_t[38] ? -$signed(VW'(rot_rnd)) : $signed(VW'(rot_rnd));
    end else if (dvd > VAL_MAX) begin
      cur_calc = $signed(VW'(VAL_MAX));
    end else begin
      cur_calc = $signed(dvd[VW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_wr) cur <= cur_calc;
  end

  // threshold compare and direction
  logic signed [VW:0] change;
  logic [VW:0] chg_mag, th;
  logic [15:0] ax, ay;
  logic [31:0] wx, wy;
  logic [3:0] g_cmp;
  assign change = {cur[VW-1], cur} - {ref_value[VW-1], ref_value};
  assign chg_mag = change[VW] ? (VW+1)'(-change) : change;
  assign ax = dx[16] ? 16'(-dx) : dx[15:0];
  assign ay = dy[16] ? 16'(-dy) : dy[15:0];
  assign wx = ax * scr_h;
  assign wy = ay * scr_w;

  always_comb begin
    case (item.kind)
      K_ROTATE: begin
        th = TH_ROTATE;
        g_cmp = G_ROTATE;
      end
      K_ZOOM: begin
        th = TH_ZOOM;
        g_cmp = change[VW] ? G_PINCH : G_SPREAD;
      end
      default: begin
        th = TH_PAN;
        if (wx < wy) begin
          g_cmp = (!dy[16] && dy != 17'sd0) ? G_DOWN : G_UP;
        end else begin
          g_cmp = (!dx[16] && dx != 17'sd0) ? G_RIGHT : G_LEFT;
        end
      end
    endcase
  end

  // gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ignore_rest <= 1'b0;
      origin_x <= '0;
      origin_y <= '0;
      ref_value <= '0;
    end else begin
      if (cmd.phase_wr) phase <= cmd.phase_val;
      if (cmd.clr_ignore) ignore_rest <= 1'b0;
      else if (cmd.set_ignore) ignore_rest <= 1'b1;
      if (cmd.origin_wr) begin
        origin_x <= item.point_x;
        origin_y <= item.point_y;
      end
      if (cmd.ref_zero) ref_value <= '0;
      else if (cmd.ref_cur) ref_value <= cur;
    end
  end

  // output register
  out_item_t ev;
  always_comb begin
    case (cmd.emit_sel)
      EM_TAP: ev = '{gesture: G_PRESS_TAP, event_x: item.point_x, event_y: item.point_y};
      EM_TWO: ev = '{gesture: G_TWO_TAP, event_x: last_x, event_y: last_y};
      default: ev = '{gesture: g_cmp, event_x: origin_x, event_y: origin_y};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_x <= '0;
      last_y <= '0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      last_x <= ev.event_x;
      last_y <= ev.event_y;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_item <= ev;
  end

  assign stat.kind = item.kind;
  assign stat.fb = item.flag_begin;
  assign stat.fe = item.flag_end;
  assign stat.ignore = ignore_rest;
  assign stat.phase = phase;
  assign stat.pzero = (item.point_x == 16'sd0) && (item.point_y == 16'sd0);
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.div_busy = div_busy;
  assign stat.over_th = chg_mag > th;
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> src/tgc_ctrl.sv
// Controller: sequences decode, multiply, square root, divide, compare and emit.
// Depends on tgc_pkg; drives tgc_datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
module tgc_ctrl
  import tgc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_SQRT   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_FINISH = 8'b0010_0000,
    S_CMP    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic to_ref, to_ref_next;
  emit_sel_t sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      to_ref <= 1'b0;
      sel <= EM_TAP;
    end else begin
      state <= state_next;
      to_ref <= to_ref_next;
      sel <= sel_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    to_ref_next = to_ref;
    sel_next = sel;
    cmd = '0;
    cmd.phase_val = PH_IDLE;
    cmd.emit_sel = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (stat.kind == K_BEGIN || stat.kind == K_END) begin
          cmd.clr_ignore = 1'b1;
          cmd.phase_wr = 1'b1;
        end else if (!stat.ignore) begin
          case (stat.kind)
            K_TWO: begin
              if (stat.fe) begin
                sel_next = EM_TWO;
                state_next = S_EMIT;
              end
            end
            K_PRESS: begin
              if (stat.fb || stat.fe) cmd.phase_wr = 1'b1;
              if (!stat.fe) cmd.phase_val = PH_WAITING;
              if (stat.fb) begin
                sel_next = EM_TAP;
                state_next = S_EMIT;
              end
            end
            K_ZOOM, K_PAN, K_ROTATE: begin
              cmd.set_ignore = stat.fe && !stat.fb;
              if (stat.fb && stat.phase == PH_IDLE) begin
                cmd.origin_wr = 1'b1;
                if (!stat.pzero) begin
                  cmd.phase_wr = 1'b1;
                  cmd.phase_val = PH_STARTED;
                  to_ref_next = 1'b1;
                  if (stat.kind == K_PAN) begin
                    cmd.ref_zero = 1'b1;
                  end else if (stat.kind == K_ZOOM) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                  end else begin
                    state_next = S_MUL;
                  end
                end
              end else if (stat.fe && stat.phase != PH_STARTED) begin
                cmd.phase_wr = 1'b1;
              end else if (!(stat.fb && !stat.fe) && stat.phase == PH_STARTED) begin
                to_ref_next = 1'b0;
                if (stat.kind == K_ZOOM) begin
                  cmd.div_start = 1'b1;
                  state_next = S_DIV;
                end else begin
                  state_next = S_MUL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (stat.kind == K_ROTATE) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!stat.sqrt_busy) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.cur_wr = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_IDLE;
        if (to_ref) begin
          cmd.ref_cur = 1'b1;
        end else if (stat.over_th) begin
          cmd.phase_wr = 1'b1;
          cmd.phase_val = PH_WAITING;
          sel_next = EM_COMPARE;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          // hold the reference until the event has taken the sign of the change
          if (sel == EM_COMPARE) cmd.ref_cur = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: controller plus datapath.
// Depends on tgc_pkg, tgc_ctrl and tgc_datapath.
`timescale 1ns / 1ps
// One report is taken at a time. Marker, tap and ignored reports use neither the
// square root nor the divider. Zoom and rotate are set by the one-bit-a-step
// divider (56 steps); pan runs the 25-step square root followed by the divider.
// Results sit in an output register, so the next report is accepted while an
// event waits to be taken. Values are signed fixed point with FRACTION_BITS
// fraction bits (8 to 24). No clearing pass runs after reset.
module touch_gesture_classifier
  import tgc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  tgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tgc_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one in work");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("emit into a full output register");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

endmodule
